### src/dll_pkg.sv
// shared constants, command codes and result type of the linked list manager
`timescale 1ns / 1ps
package dll_pkg;

  localparam int unsigned NODE_COUNT_DEF = 256;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned NODE_W         = 8;
  localparam int unsigned OUT_W          = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_ROTATE = 3'd3,
    CMD_POP    = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [OUT_W-1:0] popped_node;
    logic [OUT_W-1:0] head_node;
    logic [OUT_W-1:0] tail_node;
    logic             is_empty;
    logic             error;
  } result_t;

endpackage

### src/dll_link_mem.sv
// single port pair link memory with registered read data
`timescale 1ns / 1ps
module dll_link_mem #(
  parameter int unsigned DEPTH = dll_pkg::NODE_COUNT_DEF,
  parameter int unsigned WIDTH = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

### src/dll_ctrl.sv
// command sequencer: reads links, writes them back, keeps head and tail
`timescale 1ns / 1ps
module dll_ctrl #(
  parameter int unsigned NODE_COUNT = dll_pkg::NODE_COUNT_DEF,
  localparam int unsigned LW = $clog2(NODE_COUNT + 1),
  localparam int unsigned IW = $clog2(NODE_COUNT)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dll_pkg::CMD_W-1:0]   command_i,
  input  logic [dll_pkg::NODE_W-1:0]  node_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output dll_pkg::result_t            res_o,
  output logic [IW-1:0]               rd_addr_o,
  input  logic [LW-1:0]               nxt_rd_i,
  input  logic [LW-1:0]               prv_rd_i,
  output logic                        nxt_we_o,
  output logic [IW-1:0]               nxt_wa_o,
  output logic [LW-1:0]               nxt_wd_o,
  output logic                        prv_we_o,
  output logic [IW-1:0]               prv_wa_o,
  output logic [LW-1:0]               prv_wd_o
);

  localparam int unsigned NW = (LW > dll_pkg::NODE_W) ? LW : dll_pkg::NODE_W;
  localparam int unsigned OW = (LW > dll_pkg::OUT_W) ? LW : dll_pkg::OUT_W;
  localparam logic [LW-1:0] NONE = LW'(NODE_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WR2,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic [dll_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [dll_pkg::NODE_W-1:0]  node_q, node_d;
  logic [LW-1:0]               head_q, head_d, tail_q, tail_d;
  logic [LW-1:0]               popped_q, popped_d;
  logic                        err_q, err_d;
  logic                        nxt2_en_q, nxt2_en_d, prv2_en_q, prv2_en_d;
  logic [LW-1:0]               nxt2_addr_q, nxt2_addr_d, nxt2_data_q, nxt2_data_d;
  logic [LW-1:0]               prv2_addr_q, prv2_addr_d, prv2_data_q, prv2_data_d;

  logic                        nxt_req, prv_req;
  logic [LW-1:0]               nxt_addr, nxt_data, prv_addr, prv_data;
  logic [NW-1:0]               node_wide, in_node_wide;
  logic                        node_ok, empty;
  logic [LW-1:0]               node_link;
  logic [OW-1:0]               popped_wide, head_wide, tail_wide;

  assign node_wide    = NW'(node_q);
  assign node_ok      = node_wide < NW'(NODE_COUNT);
  assign node_link    = node_wide[LW-1:0];
  assign in_node_wide = NW'(node_i);
  assign empty        = head_q >= NONE;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  // remove reads the given node, rotate and pop read the head
  always_comb begin
    if (command_i == dll_pkg::CMD_REMOVE) begin
      rd_addr_o = in_node_wide[IW-1:0];
    end else begin
      rd_addr_o = head_q[IW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    node_d      = node_q;
    head_d      = head_q;
    tail_d      = tail_q;
    popped_d    = popped_q;
    err_d       = err_q;
    nxt2_en_d   = nxt2_en_q;
    prv2_en_d   = prv2_en_q;
    nxt2_addr_d = nxt2_addr_q;
    nxt2_data_d = nxt2_data_q;
    prv2_addr_d = prv2_addr_q;
    prv2_data_d = prv2_data_q;
    nxt_req     = 1'b0;
    prv_req     = 1'b0;
    nxt_addr    = nxt2_addr_q;
    nxt_data    = nxt2_data_q;
    prv_addr    = prv2_addr_q;
    prv_data    = prv2_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          node_d  = node_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        popped_d  = NONE;
        err_d     = 1'b0;
        nxt2_en_d = 1'b0;
        prv2_en_d = 1'b0;
        case (cmd_q)
          dll_pkg::CMD_INSERT: begin
            if (node_ok) begin
              nxt_req  = 1'b1;
              prv_req  = 1'b1;
              nxt_addr = node_link;
              prv_addr = node_link;
              prv_data = NONE;
              head_d   = node_link;
              if (empty) begin
                nxt_data = NONE;
                tail_d   = node_link;
              end else begin
                nxt_data    = head_q;
                prv2_en_d   = 1'b1;
                prv2_addr_d = head_q;
                prv2_data_d = node_link;
              end
            end
          end
          dll_pkg::CMD_APPEND: begin
            if (node_ok) begin
              nxt_req  = 1'b1;
              prv_req  = 1'b1;
              nxt_addr = node_link;
              prv_addr = node_link;
              nxt_data = NONE;
              tail_d   = node_link;
              if (empty) begin
                prv_data = NONE;
                head_d   = node_link;
              end else begin
                prv_data    = tail_q;
                nxt2_en_d   = 1'b1;
                nxt2_addr_d = tail_q;
                nxt2_data_d = node_link;
              end
            end
          end
          dll_pkg::CMD_REMOVE: begin
            if (node_ok) begin
              if (empty) begin
                err_d = 1'b1;
              end else if (head_q == node_link && tail_q == node_link) begin
                head_d = NONE;
                tail_d = NONE;
              end else if (head_q == node_link) begin
                head_d   = nxt_rd_i;
                prv_req  = 1'b1;
                prv_addr = nxt_rd_i;
                prv_data = NONE;
              end else if (tail_q == node_link) begin
                tail_d   = prv_rd_i;
                nxt_req  = 1'b1;
                nxt_addr = prv_rd_i;
                nxt_data = NONE;
              end else begin
                nxt_req  = 1'b1;
                nxt_addr = prv_rd_i;
                nxt_data = nxt_rd_i;
                prv_req  = 1'b1;
                prv_addr = nxt_rd_i;
                prv_data = prv_rd_i;
              end
            end
          end
          dll_pkg::CMD_ROTATE: begin
            if (empty) begin
              err_d = 1'b1;
            end else if (head_q != tail_q) begin
              head_d      = nxt_rd_i;
              tail_d      = head_q;
              prv_req     = 1'b1;
              prv_addr    = nxt_rd_i;
              prv_data    = NONE;
              nxt_req     = 1'b1;
              nxt_addr    = tail_q;
              nxt_data    = head_q;
              prv2_en_d   = 1'b1;
              prv2_addr_d = head_q;
              prv2_data_d = tail_q;
              nxt2_en_d   = 1'b1;
              nxt2_addr_d = head_q;
              nxt2_data_d = NONE;
            end
          end
          dll_pkg::CMD_POP: begin
            if (empty) begin
              err_d = 1'b1;
            end else begin
              popped_d = head_q;
              if (head_q == tail_q) begin
                head_d = NONE;
                tail_d = NONE;
              end else begin
                head_d   = nxt_rd_i;
                prv_req  = 1'b1;
                prv_addr = nxt_rd_i;
                prv_data = NONE;
              end
            end
          end
          default: begin
          end
        endcase
        if (nxt2_en_d || prv2_en_d) begin
          state_d = S_WR2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WR2: begin
        nxt_req = nxt2_en_q;
        prv_req = prv2_en_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // writes aimed at the none value are dropped
  assign nxt_we_o = nxt_req && (nxt_addr < NONE);
  assign prv_we_o = prv_req && (prv_addr < NONE);
  assign nxt_wa_o = nxt_addr[IW-1:0];
  assign prv_wa_o = prv_addr[IW-1:0];
  assign nxt_wd_o = nxt_data;
  assign prv_wd_o = prv_data;

  assign popped_wide       = OW'(popped_q);
  assign head_wide         = OW'(head_q);
  assign tail_wide         = OW'(tail_q);
  assign res_o.popped_node = popped_wide[dll_pkg::OUT_W-1:0];
  assign res_o.head_node   = head_wide[dll_pkg::OUT_W-1:0];
  assign res_o.tail_node   = tail_wide[dll_pkg::OUT_W-1:0];
  assign res_o.is_empty    = empty;
  assign res_o.error       = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NONE;
      tail_q  <= NONE;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    node_q      <= node_d;
    popped_q    <= popped_d;
    err_q       <= err_d;
    nxt2_en_q   <= nxt2_en_d;
    prv2_en_q   <= prv2_en_d;
    nxt2_addr_q <= nxt2_addr_d;
    nxt2_data_q <= nxt2_data_d;
    prv2_addr_q <= prv2_addr_d;
    prv2_data_q <= prv2_data_d;
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EXEC)
    else $error("accepted item did not start execution");

  a_error_keeps_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && err_d |=> $stable(head_q) && $stable(tail_q))
    else $error("error command changed head or tail");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE || state_q == S_DONE |-> !nxt_we_o && !prv_we_o)
    else $error("link write outside of execution");

  a_wr2_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR2 |-> $past(state_q) == S_EXEC)
    else $error("second write phase without execution");

endmodule

### src/doubly_linked_list_manager_top.sv
// Doubly linked list manager over a pool of node indices.
// Input channel: in_valid_i / in_ready_o with command_i and node_i. Commands are
// insert at head, append at tail, remove node, rotate head to tail, pop head.
// Output channel: out_valid_o / out_ready_i with popped_node_o, head_node_o,
// tail_node_o, is_empty_o and error_o; exactly one result per item.
// Each item passes the states accept, link read and first write, and result,
// plus a second write phase when a second write to one link memory is needed
// (insert and append on a non-empty list, rotate on two nodes or more): the
// next and previous links sit in two memories with one write port each.
// One item is worked on at a time; a new item is taken while the previous
// result waits in the output register.
// Reset empties the list (head and tail none); link memories are not cleared.
// When the receiver stalls, the result is held and the next item waits in its
// result state until the output register frees.
`timescale 1ns / 1ps
module doubly_linked_list_manager_top #(
  parameter int unsigned NODE_COUNT = dll_pkg::NODE_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dll_pkg::CMD_W-1:0]    command_i,
  input  logic [dll_pkg::NODE_W-1:0]   node_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dll_pkg::OUT_W-1:0]    popped_node_o,
  output logic [dll_pkg::OUT_W-1:0]    head_node_o,
  output logic [dll_pkg::OUT_W-1:0]    tail_node_o,
  output logic                         is_empty_o,
  output logic                         error_o
);

  localparam int unsigned LW = $clog2(NODE_COUNT + 1);
  localparam int unsigned IW = $clog2(NODE_COUNT);

  logic             res_valid, res_ready;
  dll_pkg::result_t res, out_q;
  logic             out_valid_q;
  logic [IW-1:0]    rd_addr, nxt_wa, prv_wa;
  logic [LW-1:0]    nxt_rd, prv_rd, nxt_wd, prv_wd;
  logic             nxt_we, prv_we;

  dll_ctrl #(
    .NODE_COUNT(NODE_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .node_i      (node_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .nxt_rd_i    (nxt_rd),
    .prv_rd_i    (prv_rd),
    .nxt_we_o    (nxt_we),
    .nxt_wa_o    (nxt_wa),
    .nxt_wd_o    (nxt_wd),
    .prv_we_o    (prv_we),
    .prv_wa_o    (prv_wa),
    .prv_wd_o    (prv_wd)
  );

  dll_link_mem #(
    .DEPTH(NODE_COUNT),
    .WIDTH(LW)
  ) u_next_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (nxt_rd),
    .wr_en_i   (nxt_we),
    .wr_addr_i (nxt_wa),
    .wr_data_i (nxt_wd)
  );

  dll_link_mem #(
    .DEPTH(NODE_COUNT),
    .WIDTH(LW)
  ) u_prev_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (prv_rd),
    .wr_en_i   (prv_we),
    .wr_addr_i (prv_wa),
    .wr_data_i (prv_wd)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign popped_node_o = out_q.popped_node;
  assign head_node_o   = out_q.head_node;
  assign tail_node_o   = out_q.tail_node;
  assign is_empty_o    = out_q.is_empty;
  assign error_o       = out_q.error;

endmodule
